### hdl/csv_column_type_classifier_top_assert.svh
// Assertion macros used by the classifier checker
`ifndef CSV_COLUMN_TYPE_CLASSIFIER_TOP_ASSERT_SVH
`define CSV_COLUMN_TYPE_CLASSIFIER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CCTC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("classifier check failed");

// next-cycle implication, sampled on clk, off during reset
`define CCTC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("classifier check failed");

`endif

### hdl/cctc_pkg.sv
// Shared constants, types and character helpers for the CSV column type classifier
package cctc_pkg;

	localparam int MAX_COLS = 32;
	localparam int CNT_W    = $clog2(MAX_COLS + 1);
	localparam int IDX_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	localparam logic [1:0] TYPE_INT   = 2'd0;
	localparam logic [1:0] TYPE_BOOL  = 2'd1;
	localparam logic [1:0] TYPE_FLOAT = 2'd2;
	localparam logic [1:0] TYPE_STR   = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FINISH,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic step;
		logic finish;
		logic load;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic last_col;
	} sts_t;

	// words TRUE, true, FALSE, false
	function automatic logic [7:0] bool_char(input logic [1:0] w, input logic [2:0] pos);
		logic [39:0] word;
		logic [7:0]  ch;
		case (w)
			2'd0:    word = {"TRUE", 8'h00};
			2'd1:    word = {"true", 8'h00};
			2'd2:    word = "FALSE";
			default: word = "false";
		endcase
		case (pos)
			3'd0:    ch = word[39:32];
			3'd1:    ch = word[31:24];
			3'd2:    ch = word[23:16];
			3'd3:    ch = word[15:8];
			3'd4:    ch = word[7:0];
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [2:0] bool_len(input logic [1:0] w);
		return w[1] ? 3'd5 : 3'd4;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

endpackage

### hdl/cctc_ctrl.sv
// Controller: byte intake, end-of-file finish and column flush sequencing
module cctc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             data_valid,
	input  logic             end_of_file,
	output logic             data_stall,
	output logic             result_valid,
	input  logic             result_stall,
	output cctc_pkg::cmd_t   cmd,
	input  cctc_pkg::sts_t   sts
);

	cctc_pkg::state_t state_q, state_n;
	logic             out_valid_q, out_valid_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cctc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			out_valid_q <= out_valid_n;
		end
	end

	always_comb begin
		state_n    = state_q;
		cmd        = '0;
		data_stall = 1'b1;
		case (state_q)
			cctc_pkg::ST_IDLE: begin
				data_stall = 1'b0;
				if (data_valid) begin
					cmd.step = 1'b1;
					if (end_of_file)
						state_n = cctc_pkg::ST_FINISH;
				end
			end
			cctc_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
				state_n    = cctc_pkg::ST_FLUSH;
			end
			cctc_pkg::ST_FLUSH: begin
				if (!out_valid_q || !result_stall) begin
					cmd.load = 1'b1;
					if (sts.last_col) begin
						cmd.clear = 1'b1;
						state_n   = cctc_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_n = cctc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (cmd.load)
			out_valid_n = 1'b1;
		else if (!result_stall)
			out_valid_n = 1'b0;
		else
			out_valid_n = out_valid_q;
	end

	assign result_valid = out_valid_q;

endmodule

### hdl/cctc_dp.sv
// Datapath: header column count, per-cell scan, per-column type flags, result register
module cctc_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      data_byte,
	input  cctc_pkg::cmd_t  cmd,
	output cctc_pkg::sts_t  sts,
	output logic [4:0]      col_index,
	output logic [1:0]      col_type,
	output logic [5:0]      col_count,
	output logic            cols_truncated,
	output logic            final_col
);

	localparam int MC = cctc_pkg::MAX_COLS;
	localparam int CW = cctc_pkg::CNT_W;
	localparam int IW = cctc_pkg::IDX_W;

	logic          in_header_q, in_header_n;
	logic [CW-1:0] column_count_q, column_count_n;
	logic [CW-1:0] current_column_q, current_column_n;
	logic          skip_q, skip_n;
	logic          overflowed_q, overflowed_n;
	logic [MC-1:0] int_flags_q, int_flags_n;
	logic [MC-1:0] bool_flags_q, bool_flags_n;
	logic [MC-1:0] float_flags_q, float_flags_n;
	logic          started_q, started_n;
	logic          space_q, space_n;
	logic          minus_q, minus_n;
	logic          dot_q, dot_n;
	logic          bad_q, bad_n;
	logic [3:0]    words_q, words_n;
	logic [2:0]    wlen_q, wlen_n;
	logic [IW-1:0] flush_idx_q;

	logic [4:0] col_index_q;
	logic [1:0] col_type_q;
	logic [5:0] col_count_q;
	logic       truncated_q;
	logic       final_q;

	logic          is_nl, is_sep, do_finish, do_char, fin_hit, cell_bool, cell_bad;
	logic [IW-1:0] fidx;
	logic [CW-1:0] col_inc;
	logic          last_col;
	logic [1:0]    flush_type;

	assign is_nl  = (data_byte == cctc_pkg::CH_NL);
	assign is_sep = (data_byte == cctc_pkg::CH_SEMI) || (data_byte == cctc_pkg::CH_COMMA);

	assign do_finish = !in_header_q &&
		((cmd.step && (is_nl || (is_sep && !skip_q))) || cmd.finish);
	assign do_char   = cmd.step && !in_header_q && !is_nl && !is_sep && !skip_q;

	assign fin_hit   = started_q && !skip_q && (current_column_q < column_count_q) &&
		(current_column_q < CW'(MC));
	assign cell_bool = ((|words_q[1:0]) && (wlen_q == 3'd4)) ||
		((|words_q[3:2]) && (wlen_q == 3'd5));
	assign cell_bad  = bad_q || minus_q;
	assign fidx      = current_column_q[IW-1:0];
	assign col_inc   = current_column_q + CW'(1);

	// header and column position
	always_comb begin
		in_header_n      = in_header_q;
		column_count_n   = column_count_q;
		current_column_n = current_column_q;
		skip_n           = skip_q;
		overflowed_n     = overflowed_q;
		if (cmd.step) begin
			if (in_header_q) begin
				if (is_nl) begin
					in_header_n = 1'b0;
				end else if (is_sep) begin
					if (column_count_q < CW'(MC))
						column_count_n = column_count_q + CW'(1);
					else
						overflowed_n = 1'b1;
				end
			end else if (is_nl) begin
				current_column_n = '0;
				skip_n           = 1'b0;
			end else if (is_sep && !skip_q) begin
				current_column_n = col_inc;
				if (col_inc >= column_count_q)
					skip_n = 1'b1;
			end
		end
		if (cmd.clear) begin
			in_header_n      = 1'b1;
			column_count_n   = CW'(1);
			current_column_n = '0;
			skip_n           = 1'b0;
			overflowed_n     = 1'b0;
		end
	end

	// column flags
	always_comb begin
		int_flags_n   = int_flags_q;
		bool_flags_n  = bool_flags_q;
		float_flags_n = float_flags_q;
		if (do_finish && fin_hit) begin
			if (!cell_bool)
				bool_flags_n[fidx] = 1'b0;
			if (cell_bad) begin
				int_flags_n[fidx]   = 1'b0;
				float_flags_n[fidx] = 1'b0;
			end else if (dot_q) begin
				float_flags_n[fidx] = 1'b1;
				int_flags_n[fidx]   = 1'b0;
			end
		end
		if (cmd.clear) begin
			int_flags_n   = '1;
			bool_flags_n  = '1;
			float_flags_n = '0;
		end
	end

	// cell scan
	always_comb begin
		started_n = started_q;
		space_n   = space_q;
		minus_n   = minus_q;
		dot_n     = dot_q;
		bad_n     = bad_q;
		words_n   = words_q;
		wlen_n    = wlen_q;
		if (do_char) begin
			if (cctc_pkg::is_blank(data_byte)) begin
				if (started_q)
					space_n = 1'b1;
			end else begin
				if (space_q) begin
					bad_n   = 1'b1;
					words_n = '0;
				end
				for (int w = 0; w < 4; w++) begin
					if ((wlen_q >= cctc_pkg::bool_len(2'(w))) ||
						(cctc_pkg::bool_char(2'(w), wlen_q) != data_byte))
						words_n[w] = 1'b0;
				end
				if (wlen_q != 3'd7)
					wlen_n = wlen_q + 3'd1;
				if (minus_q) begin
					if (!cctc_pkg::is_digit(data_byte))
						bad_n = 1'b1;
					minus_n = 1'b0;
				end
				if (cctc_pkg::is_digit(data_byte)) begin
					bad_n = bad_n;
				end else if (data_byte == cctc_pkg::CH_MINUS) begin
					minus_n = 1'b1;
				end else if ((data_byte == cctc_pkg::CH_DOT) && started_q && !dot_q) begin
					dot_n = 1'b1;
				end else begin
					bad_n = 1'b1;
				end
				started_n = 1'b1;
				space_n   = 1'b0;
			end
		end else if (do_finish || cmd.clear) begin
			started_n = 1'b0;
			space_n   = 1'b0;
			minus_n   = 1'b0;
			dot_n     = 1'b0;
			bad_n     = 1'b0;
			words_n   = '1;
			wlen_n    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_header_q      <= 1'b1;
			column_count_q   <= CW'(1);
			current_column_q <= '0;
			skip_q           <= 1'b0;
			overflowed_q     <= 1'b0;
			int_flags_q      <= '1;
			bool_flags_q     <= '1;
			float_flags_q    <= '0;
			started_q        <= 1'b0;
			space_q          <= 1'b0;
			minus_q          <= 1'b0;
			dot_q            <= 1'b0;
			bad_q            <= 1'b0;
			words_q          <= '1;
			wlen_q           <= '0;
			flush_idx_q      <= '0;
		end else begin
			in_header_q      <= in_header_n;
			column_count_q   <= column_count_n;
			current_column_q <= current_column_n;
			skip_q           <= skip_n;
			overflowed_q     <= overflowed_n;
			int_flags_q      <= int_flags_n;
			bool_flags_q     <= bool_flags_n;
			float_flags_q    <= float_flags_n;
			started_q        <= started_n;
			space_q          <= space_n;
			minus_q          <= minus_n;
			dot_q            <= dot_n;
			bad_q            <= bad_n;
			words_q          <= words_n;
			wlen_q           <= wlen_n;
			if (cmd.clear)
				flush_idx_q <= '0;
			else if (cmd.load)
				flush_idx_q <= flush_idx_q + IW'(1);
		end
	end

	// flush
	assign last_col = ((CW'(flush_idx_q) + CW'(1)) == column_count_q);
	assign sts.last_col = last_col;

	always_comb begin
		if (int_flags_q[flush_idx_q])
			flush_type = cctc_pkg::TYPE_INT;
		else if (bool_flags_q[flush_idx_q])
			flush_type = cctc_pkg::TYPE_BOOL;
		else if (float_flags_q[flush_idx_q])
			flush_type = cctc_pkg::TYPE_FLOAT;
		else
			flush_type = cctc_pkg::TYPE_STR;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_index_q <= 5'(flush_idx_q);
			col_type_q  <= flush_type;
			col_count_q <= 6'(column_count_q);
			truncated_q <= overflowed_q;
			final_q     <= last_col;
		end
	end

	assign col_index      = col_index_q;
	assign col_type       = col_type_q;
	assign col_count      = col_count_q;
	assign cols_truncated = truncated_q;
	assign final_col      = final_q;

endmodule

### hdl/csv_column_type_classifier_top.sv
// Input bytes: one transfer per cycle while no flush is running; stall drops with the controller idle.
// End-of-file byte: the FINISH state closes the open cell, then the FLUSH state loads one result per column
// from the flag registers into the result register, a new one whenever that register is empty or not
// stalled; input stays stalled until the last result is loaded.
// Reset (arst_n, async, active low) clears control state and restores all column flags.
module csv_column_type_classifier_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_file,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [4:0] col_index,
	output logic [1:0] col_type,
	output logic [5:0] col_count,
	output logic       cols_truncated,
	output logic       final_col
);

	cctc_pkg::cmd_t cmd;
	cctc_pkg::sts_t sts;

	cctc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.end_of_file  (end_of_file),
		.data_stall   (data_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.sts          (sts)
	);

	cctc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_byte      (data_byte),
		.cmd            (cmd),
		.sts            (sts),
		.col_index      (col_index),
		.col_type       (col_type),
		.col_count      (col_count),
		.cols_truncated (cols_truncated),
		.final_col      (final_col)
	);

endmodule

### hdl/cctc_checker.sv
// Port-level checker for the classifier top, with its bind
`include "csv_column_type_classifier_top_assert.svh"

module cctc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       data_valid,
	input logic       data_stall,
	input logic [7:0] data_byte,
	input logic       end_of_file,
	input logic       result_valid,
	input logic       result_stall,
	input logic [4:0] col_index,
	input logic [1:0] col_type,
	input logic [5:0] col_count,
	input logic       cols_truncated,
	input logic       final_col
);

	logic unused_ok;
	assign unused_ok = ^{data_byte, col_type};

	`CCTC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(col_index) && $stable(final_col))
	`CCTC_ASSERT_NOW(a_index_range, result_valid, (col_count != 6'd0) && ({1'b0, col_index} < col_count))
	`CCTC_ASSERT_NOW(a_final_last, result_valid && final_col, ({1'b0, col_index} + 6'd1) == col_count)
	`CCTC_ASSERT_NOW(a_trunc_full, result_valid && cols_truncated, col_count == 6'd32)
	`CCTC_ASSERT_NEXT(a_eof_stall, data_valid && !data_stall && end_of_file, data_stall)

endmodule

bind csv_column_type_classifier_top cctc_checker u_cctc_checker (.*);

### tb/cctc_type_checker.sv
// Checker for the CSV column type classifier: tracks byte transfers, predicts column type reports, compares results
module cctc_type_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	input  logic       data_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_file,
	input  logic       result_valid,
	input  logic       result_stall,
	input  logic [4:0] col_index,
	input  logic [1:0] col_type,
	input  logic [5:0] col_count,
	input  logic       cols_truncated,
	input  logic       final_col,
	output int         failures,
	output int         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [4:0] index;
		logic [1:0] kind;
		logic [5:0] count;
		logic       trunc;
		logic       last;
	} col_report_t;

	col_report_t type_reports[$];

	// file-level state
	logic        hdr;
	int          ncols;
	int          col;
	logic        skipping;
	logic        ovf;
	logic [31:0] int_ok;
	logic [31:0] bool_ok;
	logic [31:0] flt_ok;

	// open cell state
	logic        started;
	logic        gap;
	logic        minus_open;
	logic        has_dot;
	logic        bad;
	logic [3:0]  words;
	int          wlen;

	function automatic logic [7:0] truth_char(input int w, input int pos);
		logic [39:0] txt;
		case (w)
			0:       txt = "TRUE ";
			1:       txt = "true ";
			2:       txt = "FALSE";
			default: txt = "false";
		endcase
		return txt[39 - 8 * pos -: 8];
	endfunction

	function automatic logic blank_byte(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
	endfunction

	function automatic void open_cell();
		started    = 1'b0;
		gap        = 1'b0;
		minus_open = 1'b0;
		has_dot    = 1'b0;
		bad        = 1'b0;
		words      = 4'hF;
		wlen       = 0;
	endfunction

	function automatic void restart_file();
		hdr      = 1'b1;
		ncols    = 1;
		col      = 0;
		skipping = 1'b0;
		ovf      = 1'b0;
		int_ok   = '1;
		bool_ok  = '1;
		flt_ok   = '0;
		open_cell();
	endfunction

	function automatic void close_cell();
		logic is_word;
		logic broken;
		if (started && !skipping && col < ncols && col < cctc_pkg::MAX_COLS) begin
			broken  = bad || minus_open;
			is_word = ((words[1:0] != 2'b00) && wlen == 4) || ((words[3:2] != 2'b00) && wlen == 5);
			if (!is_word)
				bool_ok[col] = 1'b0;
			if (broken) begin
				int_ok[col] = 1'b0;
				flt_ok[col] = 1'b0;
			end else if (has_dot) begin
				flt_ok[col] = 1'b1;
				int_ok[col] = 1'b0;
			end
		end
		open_cell();
	endfunction

	function automatic void take_char(input logic [7:0] c);
		logic digit;
		digit = c >= "0" && c <= "9";
		if (blank_byte(c)) begin
			if (started)
				gap = 1'b1;
			return;
		end
		if (gap) begin
			bad   = 1'b1;
			words = 4'h0;
		end
		for (int w = 0; w < 4; w++) begin
			if (wlen >= (w < 2 ? 4 : 5))
				words[w] = 1'b0;
			else if (truth_char(w, wlen) != c)
				words[w] = 1'b0;
		end
		if (wlen < 7)
			wlen++;
		if (minus_open) begin
			if (!digit)
				bad = 1'b1;
			minus_open = 1'b0;
		end
		if (digit) begin
		end else if (c == cctc_pkg::CH_MINUS) begin
			minus_open = 1'b1;
		end else if (c == cctc_pkg::CH_DOT && started && !has_dot) begin
			has_dot = 1'b1;
		end else begin
			bad = 1'b1;
		end
		started = 1'b1;
		gap     = 1'b0;
	endfunction

	function automatic void classify_byte(input logic [7:0] c, input logic last);
		col_report_t r;
		if (hdr) begin
			if (c == cctc_pkg::CH_NL) begin
				hdr = 1'b0;
			end else if (c == cctc_pkg::CH_SEMI || c == cctc_pkg::CH_COMMA) begin
				if (ncols < cctc_pkg::MAX_COLS)
					ncols++;
				else
					ovf = 1'b1;
			end
		end else if (c == cctc_pkg::CH_NL) begin
			close_cell();
			col      = 0;
			skipping = 1'b0;
		end else if (c == cctc_pkg::CH_SEMI || c == cctc_pkg::CH_COMMA) begin
			if (!skipping) begin
				close_cell();
				col++;
				if (col >= ncols)
					skipping = 1'b1;
			end
		end else if (!skipping) begin
			take_char(c);
		end
		if (!last)
			return;
		if (!hdr)
			close_cell();
		for (int k = 0; k < ncols && k < cctc_pkg::MAX_COLS; k++) begin
			if (int_ok[k])
				r.kind = cctc_pkg::TYPE_INT;
			else if (bool_ok[k])
				r.kind = cctc_pkg::TYPE_BOOL;
			else if (flt_ok[k])
				r.kind = cctc_pkg::TYPE_FLOAT;
			else
				r.kind = cctc_pkg::TYPE_STR;
			r.index = k[4:0];
			r.count = ncols[5:0];
			r.trunc = ovf;
			r.last  = (k + 1 == ncols);
			type_reports.push_back(r);
		end
		restart_file();
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk) begin : watch
		col_report_t want;
		if (!arst_n) begin
			restart_file();
			type_reports.delete();
			failures    = 0;
			outstanding = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (type_reports.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual column %0d",
						$time, col_index);
					failures++;
				end else begin
					want = type_reports.pop_front();
					check_field("col_index", 8'(want.index), 8'(col_index));
					check_field("col_type", 8'(want.kind), 8'(col_type));
					check_field("col_count", 8'(want.count), 8'(col_count));
					check_field("cols_truncated", 8'(want.trunc), 8'(cols_truncated));
					check_field("final_col", 8'(want.last), 8'(final_col));
				end
			end
			if (data_valid && !data_stall)
				classify_byte(data_byte, end_of_file);
			outstanding = type_reports.size();
		end
	end

endmodule

### tb/tb_csv_column_type_classifier_top.sv
// Testbench top for the CSV column type classifier: byte stimulus, result stalls and verdict
module tb_csv_column_type_classifier_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int {
		CELL_INT,
		CELL_FLOAT,
		CELL_BOOL,
		CELL_EMPTY,
		CELL_ODD,
		CELL_JUNK
	} cell_kind_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       data_valid   = 1'b0;
	logic [7:0] data_byte    = 8'h00;
	logic       end_of_file  = 1'b0;
	logic       result_stall = 1'b0;
	logic       data_stall;
	logic       result_valid;
	logic [4:0] col_index;
	logic [1:0] col_type;
	logic [5:0] col_count;
	logic       cols_truncated;
	logic       final_col;
	int         failures;
	int         outstanding;

	logic       quiet         = 1'b0;
	int         holds_asked   = 0;
	int         holds_granted = 0;
	logic [7:0] file_text[$];

	csv_column_type_classifier_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.data_byte(data_byte),
		.end_of_file(end_of_file),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.col_index(col_index),
		.col_type(col_type),
		.col_count(col_count),
		.cols_truncated(cols_truncated),
		.final_col(final_col)
	);

	cctc_type_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.data_byte(data_byte),
		.end_of_file(end_of_file),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.col_index(col_index),
		.col_type(col_type),
		.col_count(col_count),
		.cols_truncated(cols_truncated),
		.final_col(final_col),
		.failures(failures),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// result side; a requested hold keeps stall high for a long stretch
	initial begin
		forever begin
			@(posedge clk);
			if (holds_granted != holds_asked) begin
				holds_granted = holds_granted + 1;
				result_stall <= 1'b1;
				repeat (80) @(posedge clk);
			end
			result_stall <= !quiet && ($urandom_range(99) < 10);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while (!quiet && $urandom_range(99) < 10) begin
			data_valid <= 1'b0;
			@(posedge clk);
		end
		data_valid  <= 1'b1;
		data_byte   <= b;
		end_of_file <= last;
		@(posedge clk);
		while (data_stall)
			@(posedge clk);
	endtask

	task automatic send_text(input string s, input logic last);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], last && i == s.len() - 1);
	endtask

	task automatic send_file(inout int sent);
		for (int i = 0; i < file_text.size(); i++)
			send_byte(file_text[i], i == file_text.size() - 1);
		sent += file_text.size();
	endtask

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(4))
			0:       return 8'h20;
			1:       return 8'h09;
			2:       return 8'h0B;
			3:       return 8'h0C;
			default: return 8'h0D;
		endcase
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			file_text.push_back(s[i]);
	endfunction

	function automatic void add_digits(input int n);
		for (int i = 0; i < n; i++)
			file_text.push_back(8'(8'h30 + $urandom_range(9)));
	endfunction

	function automatic void add_cell(input cell_kind_t kind);
		int    pad;
		int    mangle;
		string word;
		pad = $urandom_range(3);
		if (pad[0])
			file_text.push_back(pick_blank());
		case (kind)
			CELL_INT: begin
				if ($urandom_range(2) == 0)
					file_text.push_back(cctc_pkg::CH_MINUS);
				add_digits($urandom_range(1, 3));
			end
			CELL_FLOAT: begin
				if ($urandom_range(2) == 0)
					file_text.push_back(cctc_pkg::CH_MINUS);
				add_digits($urandom_range(1, 2));
				file_text.push_back(cctc_pkg::CH_DOT);
				add_digits($urandom_range(1, 2));
			end
			CELL_BOOL: begin
				case ($urandom_range(3))
					0:       word = "TRUE";
					1:       word = "true";
					2:       word = "FALSE";
					default: word = "false";
				endcase
				mangle = $urandom_range(5);
				for (int i = 0; i < word.len() - (mangle == 0); i++)
					file_text.push_back((mangle == 1 && i == 1) ? word[i] ^ 8'h20 : word[i]);
				if (mangle == 2)
					file_text.push_back("e");
			end
			CELL_EMPTY: begin
			end
			CELL_ODD: begin
				case ($urandom_range(6))
					0:       add_text("-");
					1:       add_text(".5");
					2:       add_text("5.");
					3:       add_text("1.2.3");
					4:       add_text("1 2");
					5:       add_text("-x");
					default: add_text("--1");
				endcase
			end
			default: begin
				repeat ($urandom_range(1, 3))
					file_text.push_back(8'($urandom_range(255)));
			end
		endcase
		if (pad[1])
			file_text.push_back(pick_blank());
	endfunction

	// nrows == 0 ends the file inside the header line
	function automatic void build_file(input int ncols, input int nrows);
		cell_kind_t main_kind[40];
		logic [7:0] b;
		int         ncells;
		int         sel;
		file_text.delete();
		for (int k = 0; k < ncols; k++) begin
			repeat ($urandom_range(3)) begin
				b = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
					: 8'("a" + $urandom_range(25));
				if (b == cctc_pkg::CH_NL || b == cctc_pkg::CH_SEMI || b == cctc_pkg::CH_COMMA)
					b = "h";
				file_text.push_back(b);
			end
			if (k < ncols - 1)
				file_text.push_back($urandom_range(1) ? cctc_pkg::CH_SEMI : cctc_pkg::CH_COMMA);
		end
		if (nrows > 0)
			file_text.push_back(cctc_pkg::CH_NL);
		for (int k = 0; k < 40; k++)
			main_kind[k] = ($urandom_range(9) < 8) ? cell_kind_t'($urandom_range(2))
				: cell_kind_t'($urandom_range(5));
		for (int r = 0; r < nrows; r++) begin
			sel = $urandom_range(9);
			if (ncols > 8)
				ncells = (sel < 5) ? $urandom_range(1, 6) : ncols;
			else if (sel == 0)
				ncells = $urandom_range(1, ncols);
			else if (sel == 1)
				ncells = ncols + $urandom_range(1, 2);
			else
				ncells = ncols;
			for (int c = 0; c < ncells; c++) begin
				if (c > 0)
					file_text.push_back($urandom_range(1) ? cctc_pkg::CH_SEMI
						: cctc_pkg::CH_COMMA);
				if (c < ncols && $urandom_range(99) < 85)
					add_cell(main_kind[c]);
				else
					add_cell(cell_kind_t'($urandom_range(5)));
			end
			if (r < nrows - 1 || $urandom_range(1))
				file_text.push_back(cctc_pkg::CH_NL);
		end
		if (file_text.size() == 0)
			file_text.push_back("h");
	endfunction

	initial begin
		int nfile;
		int random_bytes;
		int ncols;
		int nrows;
		int spin;
		nfile        = 0;
		random_bytes = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("\n", 1'b1);
		send_text("a,", 1'b1);
		send_text("c,d\n-7;x", 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("\n1. , FALSE;9\n.5", 1'b1);

		while (random_bytes < 140 || nfile < 3) begin
			quiet = (nfile == 1 || nfile == 2);
			if (nfile == 0) begin
				holds_asked = holds_asked + 1;
				build_file(2, 1);
			end else if (nfile == 1) begin
				build_file(33 + $urandom_range(2), 0);
			end else begin
				ncols = ($urandom_range(4) == 0) ? $urandom_range(7, 32) : $urandom_range(1, 6);
				nrows = ($urandom_range(9) == 0) ? 0 : (ncols > 8) ? 1 : $urandom_range(1, 3);
				build_file(ncols, nrows);
			end
			send_file(random_bytes);
			if (nfile == 2) begin
				data_valid <= 1'b0;
				@(posedge clk);
				while (outstanding != 0)
					@(posedge clk);
			end
			nfile++;
		end
		quiet = 1'b0;

		data_valid <= 1'b0;
		@(posedge clk);
		spin = 0;
		while (outstanding != 0 && spin < 5000) begin
			@(posedge clk);
			spin++;
		end
		repeat (10) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
